// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the RGB to HSV converter.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent must be followed by the consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The antecedent must be followed by the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rhc_pkg.sv =====
// Package for the RGB to HSV converter: hue sector codes and sector offset shifts.
// No dependencies.
package rhc_pkg;

   // Which channel is the largest; ties go to red, then to green.
   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // Shift amounts that give the offsets of the hue sectors as multiples of delta.
   localparam int unsigned GREEN_SHIFT = 1;
   localparam int unsigned BLUE_SHIFT  = 2;

endpackage

// ===== sv/rhc_rgb_if.sv =====
// Valid/ready channel that carries one RGB pixel per item.
// No dependencies.
interface rhc_rgb_if #(
   parameter int CHANNEL_BITS = 8
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red;
   logic [CHANNEL_BITS-1:0] green;
   logic [CHANNEL_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== sv/rhc_hsv_if.sv =====
// Valid/ready channel that carries one HSV pixel per item.
// No dependencies.
interface rhc_hsv_if #(
   parameter int CHANNEL_BITS = 8,
   parameter int HUE_BITS     = 16
);
   logic                    valid;
   logic                    ready;
   logic [HUE_BITS-1:0]     hue;
   logic [CHANNEL_BITS-1:0] saturation;
   logic [CHANNEL_BITS-1:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness, input ready);
   modport sink   (input valid, input hue, input saturation, input brightness, output ready);
endinterface

// ===== sv/rgb_to_hsv_convert.sv =====
// RGB to HSV converter: top level, a fully pipelined datapath.
// Depends on rhc_pkg, rhc_rgb_if, rhc_hsv_if and assert_macros.svh.
//
// Usage:
//   req_pixel carries one pixel (red, green, blue) per item; rsp_pixel returns
//   hue (Q0.HUE_BITS fraction of a turn), saturation and brightness (value).
//   An accepted item passes through stage 1, stage 2, the divider setup stage
//   and the divider stages before it raises rsp_pixel.valid.
//   Throughput is one item per cycle while the receiver does not stall. Both
//   divisions are restoring dividers unrolled one quotient bit per pipeline
//   stage.
//   The pipeline advances as a whole whenever its output register is empty or
//   the receiver takes the item there. When the receiver stalls, every stage
//   holds, req_pixel.ready falls in the same cycle and no item is lost or
//   repeated. req_pixel.ready depends combinationally on rsp_pixel.ready.
//   Reset (synchronous, active high) empties the pipeline; there is no other
//   state. Black and grey pixels give hue zero and saturation zero.
`include "assert_macros.svh"

module rgb_to_hsv_convert
   import rhc_pkg::*;
#(
   parameter int CHANNEL_BITS = 8,
   parameter int HUE_BITS     = 16
) (
   input  logic      clock,
   input  logic      reset,
   rhc_rgb_if.sink   req_pixel,
   rhc_hsv_if.source rsp_pixel
);

   localparam int CW = CHANNEL_BITS;
   localparam int HW = HUE_BITS;
   localparam int DW = CW + 3;              // holds 6 * delta
   localparam int NW = CW + 4;              // signed hue numerator
   localparam int NS = (CW > HW) ? CW : HW; // divider stages

   logic adv;

   // Stage 1: largest and smallest channel.
   logic          s1_v_ff;
   logic [CW-1:0] s1_r_ff, s1_g_ff, s1_b_ff, s1_mx_ff, s1_mn_ff;
   sector_type    s1_sec_ff;
   logic [CW-1:0] s1_mx_in, s1_mn_in;
   sector_type    s1_sec_in;

   // Stage 2: delta and the difference of the other two channels.
   logic          s2_v_ff;
   logic [CW-1:0] s2_delta_ff, s2_mx_ff;
   logic [CW:0]   s2_diff_ff;
   sector_type    s2_sec_ff;
   logic [CW:0]   s2_diff_in;

   // Divider pipeline; index 0 is the setup stage.
   logic [NS:0]   dv_v_ff;
   logic [DW-1:0] dv_hrem_ff [NS+1];
   logic [DW-1:0] dv_d6_ff   [NS+1];
   logic [HW-1:0] dv_hq_ff   [NS+1];
   logic [CW-1:0] dv_srem_ff [NS+1];
   logic [CW-1:0] dv_slow_ff [NS+1];
   logic [CW-1:0] dv_sq_ff   [NS+1];
   logic [CW-1:0] dv_mx_ff   [NS+1];
   logic          dv_zero_ff [NS+1];

   logic [NW-1:0]   st_dext, st_d6, st_diff, st_offs, st_num;
   logic [2*CW-1:0] st_sdiv;

   assign adv             = !dv_v_ff[NS] || rsp_pixel.ready;
   assign req_pixel.ready = adv;

   // ---------------- stage 1 ----------------
   always_comb begin
      if (req_pixel.red >= req_pixel.green && req_pixel.red >= req_pixel.blue) begin
         s1_sec_in = SECTOR_RED;
         s1_mx_in  = req_pixel.red;
      end else if (req_pixel.green >= req_pixel.blue) begin
         s1_sec_in = SECTOR_GREEN;
         s1_mx_in  = req_pixel.green;
      end else begin
         s1_sec_in = SECTOR_BLUE;
         s1_mx_in  = req_pixel.blue;
      end
      s1_mn_in = req_pixel.red;
      if (req_pixel.green < s1_mn_in) begin
         s1_mn_in = req_pixel.green;
      end
      if (req_pixel.blue < s1_mn_in) begin
         s1_mn_in = req_pixel.blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_pixel.valid;
      end
      if (adv) begin
         s1_r_ff   <= req_pixel.red;
         s1_g_ff   <= req_pixel.green;
         s1_b_ff   <= req_pixel.blue;
         s1_mx_ff  <= s1_mx_in;
         s1_mn_ff  <= s1_mn_in;
         s1_sec_ff <= s1_sec_in;
      end
   end

   // ---------------- stage 2 ----------------
   always_comb begin
      case (s1_sec_ff)
         SECTOR_RED:   s2_diff_in = {1'b0, s1_g_ff} - {1'b0, s1_b_ff};
         SECTOR_GREEN: s2_diff_in = {1'b0, s1_b_ff} - {1'b0, s1_r_ff};
         SECTOR_BLUE:  s2_diff_in = {1'b0, s1_r_ff} - {1'b0, s1_g_ff};
         default:      s2_diff_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
      if (adv) begin
         s2_delta_ff <= s1_mx_ff - s1_mn_ff;
         s2_mx_ff    <= s1_mx_ff;
         s2_diff_ff  <= s2_diff_in;
         s2_sec_ff   <= s1_sec_ff;
      end
   end

   // ---------------- stage 3: divider setup ----------------
   // The hue numerator is kept below 6 * delta, so the hue quotient is purely
   // fractional. A negative numerator only occurs in the red sector and wraps
   // by one full turn.
   always_comb begin
      st_dext = {4'b0, s2_delta_ff};
      st_d6   = (st_dext << 2) + (st_dext << 1);
      st_diff = {{3{s2_diff_ff[CW]}}, s2_diff_ff};
      case (s2_sec_ff)
         SECTOR_RED:   st_offs = s2_diff_ff[CW] ? st_d6 : '0;
         SECTOR_GREEN: st_offs = st_dext << GREEN_SHIFT;
         SECTOR_BLUE:  st_offs = st_dext << BLUE_SHIFT;
         default:      st_offs = '0;
      endcase
      st_num  = st_diff + st_offs;
      // Saturation dividend: full scale times delta.
      st_sdiv = {s2_delta_ff, {CW{1'b0}}} - {{CW{1'b0}}, s2_delta_ff};
   end

   // Valid bits of the setup stage and of every divider stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff <= '0;
      end else if (adv) begin
         dv_v_ff <= {dv_v_ff[NS-1:0], s2_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_hrem_ff[0] <= st_num[DW-1:0];
         dv_d6_ff[0]   <= st_d6[DW-1:0];
         dv_hq_ff[0]   <= '0;
         dv_srem_ff[0] <= st_sdiv[2*CW-1:CW];
         dv_slow_ff[0] <= st_sdiv[CW-1:0];
         dv_sq_ff[0]   <= '0;
         dv_mx_ff[0]   <= s2_mx_ff;
         dv_zero_ff[0] <= (s2_delta_ff == '0);
      end
   end

   // ---------------- divider stages ----------------
   for (genvar k = 1; k <= NS; k++) begin : g_div
      logic [DW-1:0] hrem_in;
      logic [HW-1:0] hq_in;
      logic [CW-1:0] srem_in, slow_in, sq_in;

      if (k <= HW) begin : g_hue
         logic [DW:0] trial;
         always_comb begin
            trial = {dv_hrem_ff[k-1], 1'b0};
            if (trial >= {1'b0, dv_d6_ff[k-1]}) begin
               hrem_in = DW'(trial - {1'b0, dv_d6_ff[k-1]});
               hq_in   = {dv_hq_ff[k-1][HW-2:0], 1'b1};
            end else begin
               hrem_in = trial[DW-1:0];
               hq_in   = {dv_hq_ff[k-1][HW-2:0], 1'b0};
            end
         end
      end else begin : g_hue_pass
         assign hrem_in = dv_hrem_ff[k-1];
         assign hq_in   = dv_hq_ff[k-1];
      end

      if (k <= CW) begin : g_sat
         logic [CW:0] trial;
         always_comb begin
            trial   = {dv_srem_ff[k-1], dv_slow_ff[k-1][CW-1]};
            slow_in = {dv_slow_ff[k-1][CW-2:0], 1'b0};
            if (trial >= {1'b0, dv_mx_ff[k-1]}) begin
               srem_in = CW'(trial - {1'b0, dv_mx_ff[k-1]});
               sq_in   = {dv_sq_ff[k-1][CW-2:0], 1'b1};
            end else begin
               srem_in = trial[CW-1:0];
               sq_in   = {dv_sq_ff[k-1][CW-2:0], 1'b0};
            end
         end
      end else begin : g_sat_pass
         assign srem_in = dv_srem_ff[k-1];
         assign slow_in = dv_slow_ff[k-1];
         assign sq_in   = dv_sq_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_hrem_ff[k] <= hrem_in;
            dv_d6_ff[k]   <= dv_d6_ff[k-1];
            dv_hq_ff[k]   <= hq_in;
            dv_srem_ff[k] <= srem_in;
            dv_slow_ff[k] <= slow_in;
            dv_sq_ff[k]   <= sq_in;
            dv_mx_ff[k]   <= dv_mx_ff[k-1];
            dv_zero_ff[k] <= dv_zero_ff[k-1];
         end
      end
   end

   // ---------------- output ----------------
   // Grey and black pixels divide by zero in the pipeline; their quotients
   // are discarded here.
   assign rsp_pixel.valid      = dv_v_ff[NS];
   assign rsp_pixel.hue        = dv_zero_ff[NS] ? '0 : dv_hq_ff[NS];
   assign rsp_pixel.saturation = dv_zero_ff[NS] ? '0 : dv_sq_ff[NS];
   assign rsp_pixel.brightness = dv_mx_ff[NS];

   `ASSERT_IMPLY(a_grey_has_no_hue, rsp_pixel.valid && rsp_pixel.saturation == '0, rsp_pixel.hue == '0, "item with zero saturation has nonzero hue")
   `ASSERT_IMPLY(a_black_is_grey, rsp_pixel.valid && rsp_pixel.brightness == '0, rsp_pixel.saturation == '0, "black item has nonzero saturation")
   `ASSERT_NEXT(a_stall_holds_pipe, !adv, $stable({s1_v_ff, s2_v_ff, dv_v_ff}), "pipeline moved while stalled")
   `ASSERT_IMPLY(a_remainders_bounded, dv_v_ff[NS] && !dv_zero_ff[NS], dv_hrem_ff[NS] < dv_d6_ff[NS] && dv_srem_ff[NS] < dv_mx_ff[NS], "divider remainder out of range")

endmodule

// ===== dv/rgb_to_hsv_convert_checker.sv =====
// Checker for the RGB to HSV converter: watches both pixel channels, predicts each result
// and compares it field by field. Depends on rhc_pkg, rhc_rgb_if and rhc_hsv_if.
`timescale 1ns / 1ps

module rgb_to_hsv_convert_checker
   import rhc_pkg::*;
#(
   parameter int CHANNEL_BITS = 8,
   parameter int HUE_BITS     = 16
) (
   input  logic clock,
   input  logic reset,
   rhc_rgb_if   pixel_in,
   rhc_hsv_if   pixel_out,
   output int   fail_count,
   output int   pending_count
);

   typedef struct packed {
      logic [HUE_BITS-1:0]     hue;
      logic [CHANNEL_BITS-1:0] saturation;
      logic [CHANNEL_BITS-1:0] brightness;
   } hsv_pixel_type;

   hsv_pixel_type expected_hsv_q[$];
   int            failures = 0;

   // Exact integer form of hue = (offset + diff / delta) / 6, wrapped into one turn.
   function automatic hsv_pixel_type predict_hsv(input logic [CHANNEL_BITS-1:0] r,
                                                 input logic [CHANNEL_BITS-1:0] g,
                                                 input logic [CHANNEL_BITS-1:0] b);
      longint        red_v;
      longint        green_v;
      longint        blue_v;
      longint        top;
      longint        bottom;
      longint        delta;
      longint        num;
      longint        quotient;
      longint        full_scale;
      sector_type    sector;
      hsv_pixel_type px;
      red_v      = longint'(r);
      green_v    = longint'(g);
      blue_v     = longint'(b);
      full_scale = (longint'(1) << CHANNEL_BITS) - 1;
      // Strict comparisons give ties to red first, then to green.
      top    = red_v;
      sector = SECTOR_RED;
      if (green_v > top) begin
         top    = green_v;
         sector = SECTOR_GREEN;
      end
      if (blue_v > top) begin
         top    = blue_v;
         sector = SECTOR_BLUE;
      end
      bottom = red_v;
      if (green_v < bottom) bottom = green_v;
      if (blue_v < bottom) bottom = blue_v;
      delta = top - bottom;
      px = '0;
      px.brightness = top[CHANNEL_BITS-1:0];
      // Black and grey pixels keep hue and saturation at zero.
      if (delta != 0) begin
         quotient      = (full_scale * delta) / top;
         px.saturation = quotient[CHANNEL_BITS-1:0];
         case (sector)
            SECTOR_RED:   num = green_v - blue_v;
            SECTOR_GREEN: num = 2 * delta + (blue_v - red_v);
            default:      num = 4 * delta + (red_v - green_v);
         endcase
         if (num < 0) num = num + 6 * delta;
         quotient = (num << HUE_BITS) / (6 * delta);
         px.hue   = quotient[HUE_BITS-1:0];
      end
      return px;
   endfunction

   always @(posedge clock) begin
      hsv_pixel_type want;
      if (reset) begin
         expected_hsv_q.delete();
      end else begin
         if (pixel_in.valid && pixel_in.ready) begin
            expected_hsv_q.push_back(predict_hsv(pixel_in.red, pixel_in.green,
                                                 pixel_in.blue));
         end
         if (pixel_out.valid && pixel_out.ready) begin
            if (expected_hsv_q.size() == 0) begin
               $error("unexpected result item: hue %0d saturation %0d brightness %0d",
                      pixel_out.hue, pixel_out.saturation, pixel_out.brightness);
               failures++;
            end else begin
               want = expected_hsv_q.pop_front();
               if (pixel_out.hue !== want.hue) begin
                  $error("hue: expected %0d, actual %0d", want.hue, pixel_out.hue);
                  failures++;
               end
               if (pixel_out.saturation !== want.saturation) begin
                  $error("saturation: expected %0d, actual %0d",
                         want.saturation, pixel_out.saturation);
                  failures++;
               end
               if (pixel_out.brightness !== want.brightness) begin
                  $error("brightness: expected %0d, actual %0d",
                         want.brightness, pixel_out.brightness);
                  failures++;
               end
            end
         end
      end
      fail_count    <= failures;
      pending_count <= expected_hsv_q.size();
   end

endmodule

// ===== dv/rgb_to_hsv_convert_tb.sv =====
// Testbench top for the RGB to HSV converter: clock, reset, pixel stimulus and verdict.
// Depends on rgb_to_hsv_convert, rgb_to_hsv_convert_checker and the two channel interfaces.
`timescale 1ns / 1ps

module rgb_to_hsv_convert_tb;

   localparam int CHANNEL_BITS = 8;
   localparam int HUE_BITS     = 16;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 500;

   logic clock;
   logic reset;
   int   gap_pct;
   int   stall_pct;
   int   fail_count;
   int   pending_count;

   rhc_rgb_if #(.CHANNEL_BITS(CHANNEL_BITS)) req_pixel ();
   rhc_hsv_if #(.CHANNEL_BITS(CHANNEL_BITS), .HUE_BITS(HUE_BITS)) rsp_pixel ();

   rgb_to_hsv_convert #(
      .CHANNEL_BITS(CHANNEL_BITS),
      .HUE_BITS    (HUE_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_pixel(req_pixel),
      .rsp_pixel(rsp_pixel)
   );

   rgb_to_hsv_convert_checker #(
      .CHANNEL_BITS(CHANNEL_BITS),
      .HUE_BITS    (HUE_BITS)
   ) checker_i (
      .clock        (clock),
      .reset        (reset),
      .pixel_in     (req_pixel),
      .pixel_out    (rsp_pixel),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3_200_000;
      $display("Simulation FAILED");
      $finish;
   end

   // The receiver stalls at the rate of the current phase.
   always @(posedge clock) begin
      rsp_pixel.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_pixel(input logic [CHANNEL_BITS-1:0] r,
                             input logic [CHANNEL_BITS-1:0] g,
                             input logic [CHANNEL_BITS-1:0] b);
      while ($urandom_range(99) < gap_pct) begin
         req_pixel.valid <= 1'b0;
         req_pixel.red   <= CHANNEL_BITS'($urandom);
         req_pixel.green <= CHANNEL_BITS'($urandom);
         req_pixel.blue  <= CHANNEL_BITS'($urandom);
         @(posedge clock);
      end
      req_pixel.valid <= 1'b1;
      req_pixel.red   <= r;
      req_pixel.green <= g;
      req_pixel.blue  <= b;
      @(posedge clock);
      while (!req_pixel.ready) @(posedge clock);
   endtask

   // Uniform pixels half of the time, else greys, ties, extremes, small values or tiny deltas.
   task automatic send_random_pixel();
      logic [CHANNEL_BITS-1:0] c [3];
      logic [CHANNEL_BITS-1:0] edge_vals [4];
      int                      pick;
      int                      k;
      edge_vals = '{8'd0, 8'd1, 8'd254, 8'd255};
      foreach (c[i]) c[i] = CHANNEL_BITS'($urandom);
      pick = $urandom_range(9);
      case (pick)
         5: begin
            c[1] = c[0];
            c[2] = c[0];
         end
         6: begin
            k = $urandom_range(2);
            c[(k + 1) % 3] = c[k];
            if (c[(k + 2) % 3] > c[k]) c[(k + 2) % 3] = c[k] - 1'b1;
         end
         7: foreach (c[i]) c[i] = edge_vals[$urandom_range(3)];
         8: foreach (c[i]) c[i] = CHANNEL_BITS'($urandom_range(3));
         9: begin
            c[1] = CHANNEL_BITS'(c[0] + $urandom_range(2) - 1);
            c[2] = CHANNEL_BITS'(c[0] + $urandom_range(2) - 1);
         end
         default: ;
      endcase
      send_pixel(c[0], c[1], c[2]);
   endtask

   task automatic run_phase(input int gap, input int stall);
      gap_pct   = gap;
      stall_pct = stall;
      repeat (PHASE_ITEMS) send_random_pixel();
   endtask

   initial begin
      gap_pct         = 0;
      stall_pct       = 0;
      reset           <= 1'b1;
      req_pixel.valid <= 1'b0;
      req_pixel.red   <= '0;
      req_pixel.green <= '0;
      req_pixel.blue  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Black, white, greys and the primaries.
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd1, 8'd1, 8'd1);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      // Red largest with blue above green, so the hue wraps around.
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd200, 8'd10, 8'd100);
      // Ties for the largest channel.
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd77, 8'd77, 8'd20);
      send_pixel(8'd3, 8'd90, 8'd90);
      // Smallest deltas, smallest nonzero maxima and two further hues.
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd1, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd254, 8'd255, 8'd254);
      send_pixel(8'd254, 8'd254, 8'd255);
      send_pixel(8'd170, 8'd85, 8'd0);
      send_pixel(8'd85, 8'd0, 8'd170);

      run_phase(0, 0);
      run_phase(87, 0);
      run_phase(0, 87);
      run_phase(18, 18);
      req_pixel.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_count != 0) $error("%0d result items never arrived", pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/rhc_pkg.sv
sv/rhc_rgb_if.sv
sv/rhc_hsv_if.sv
sv/rgb_to_hsv_convert.sv
dv/rgb_to_hsv_convert_checker.sv
dv/rgb_to_hsv_convert_tb.sv
